/* rtl/core/xsr_pkg.sv */
// Shared types and constants for the xorshift128 ranged random block.
package xsr_pkg;

   localparam logic [31:0] SEED_A_RESET = 32'd123456789;
   localparam logic [31:0] SEED_B_RESET = 32'd362436069;
   localparam logic [31:0] SEED_C_RESET = 32'd521288629;
   localparam logic [31:0] SEED_D_RESET = 32'd88675123;

   localparam int unsigned SHIFT_A = 11;
   localparam int unsigned SHIFT_D = 19;
   localparam int unsigned SHIFT_T = 8;

   localparam int unsigned CSR_ADDR_W = 4;

   typedef enum logic [1:0] {
      CMD_RAW   = 2'd0,
      CMD_MOD   = 2'd1,
      CMD_RANGE = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      REG_SEED_A = 2'd0,
      REG_SEED_B = 2'd1,
      REG_SEED_C = 2'd2,
      REG_SEED_D = 2'd3
   } reg_idx_type;

   typedef struct packed {
      logic [1:0]         command;
      logic [31:0]        modulus;
      logic signed [31:0] range_min;
      logic signed [31:0] range_max;
   } req_type;

   typedef struct packed {
      logic [31:0] value;
      logic        zero_modulus;
   } rsp_type;

   // Seed load from the register port.
   typedef struct packed {
      logic        en;
      reg_idx_type idx;
      logic [31:0] data;
   } seed_wr_type;

   // One classified job. rem clear: result is base and flag as they stand.
   // rem set: result is base + word % divisor (wrapping add).
   typedef struct packed {
      logic        rem;
      logic [31:0] word;
      logic [31:0] divisor;
      logic [31:0] base;
      logic        flag;
   } job_type;

   typedef struct packed {
      logic empty;
      logic full;
   } q_stat_type;

endpackage

/* rtl/core/xsr_front.sv */
// Front end: accepts request beats, steps the generator and classifies each job.
module xsr_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  xsr_pkg::req_type    req_data,
   output logic                req_stall,
   input  xsr_pkg::seed_wr_type seed_wr,
   input  xsr_pkg::q_stat_type q_stat,
   output logic                q_push,
   output xsr_pkg::job_type    q_job
);
   import xsr_pkg::*;

   logic [31:0] gen_a_ff, gen_b_ff, gen_c_ff, gen_d_ff;
   logic [31:0] gen_a_in, gen_b_in, gen_c_in, gen_d_in;
   logic [31:0] t_word;
   logic [31:0] next_word;
   logic [31:0] span;
   logic        advance;
   logic        accept;

   assign req_stall = q_stat.full;
   assign accept    = req_valid && !q_stat.full;
   assign q_push    = accept;

   assign t_word    = gen_a_ff ^ (gen_a_ff << SHIFT_A);
   assign next_word = (gen_d_ff ^ (gen_d_ff >> SHIFT_D)) ^ (t_word ^ (t_word >> SHIFT_T));
   assign span      = 32'(req_data.range_max - req_data.range_min);

   always_comb begin
      q_job   = '0;
      advance = 1'b0;
      case (cmd_type'(req_data.command))
         CMD_RAW: begin
            q_job.base = next_word;
            advance    = 1'b1;
         end
         CMD_MOD: begin
            if (req_data.modulus == '0) begin
               q_job.flag = 1'b1;
            end else begin
               q_job.rem     = 1'b1;
               q_job.word    = next_word;
               q_job.divisor = req_data.modulus;
               advance       = 1'b1;
            end
         end
         CMD_RANGE: begin
            q_job.base = req_data.range_min;
            if (req_data.range_min != req_data.range_max) begin
               q_job.rem     = 1'b1;
               q_job.word    = next_word;
               q_job.divisor = span;
               advance       = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      gen_a_in = gen_a_ff;
      gen_b_in = gen_b_ff;
      gen_c_in = gen_c_ff;
      gen_d_in = gen_d_ff;
      if (seed_wr.en) begin
         unique case (seed_wr.idx)
            REG_SEED_A: gen_a_in = seed_wr.data;
            REG_SEED_B: gen_b_in = seed_wr.data;
            REG_SEED_C: gen_c_in = seed_wr.data;
            REG_SEED_D: gen_d_in = seed_wr.data;
            default: begin
            end
         endcase
      end else if (accept && advance) begin
         gen_a_in = gen_b_ff;
         gen_b_in = gen_c_ff;
         gen_c_in = gen_d_ff;
         gen_d_in = next_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gen_a_ff <= SEED_A_RESET;
         gen_b_ff <= SEED_B_RESET;
         gen_c_ff <= SEED_C_RESET;
         gen_d_ff <= SEED_D_RESET;
      end else begin
         gen_a_ff <= gen_a_in;
         gen_b_ff <= gen_b_in;
         gen_c_ff <= gen_c_in;
         gen_d_ff <= gen_d_in;
      end
   end

endmodule

/* rtl/core/xsr_queue.sv */
// Short job queue between front and back end.
module xsr_queue #(
   parameter int unsigned DEPTH = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  xsr_pkg::job_type    push_job,
   input  logic                pop,
   output xsr_pkg::job_type    head_job,
   output xsr_pkg::q_stat_type stat
);
   import xsr_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

   job_type           slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign stat.empty = (count_ff == '0);
   assign stat.full  = (count_ff == CNT_W'(DEPTH));
   assign head_job   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      if (pop)  rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      if (push && !pop)      count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_job;
   end

endmodule

/* rtl/core/xsr_back.sv */
// Back end: radix-2 remainder unit, range offset add and result register.
module xsr_back (
   input  logic                clock,
   input  logic                reset,
   input  xsr_pkg::q_stat_type q_stat,
   input  xsr_pkg::job_type    q_job,
   output logic                q_pop,
   output logic                rsp_valid,
   output xsr_pkg::rsp_type    rsp_data,
   input  logic                rsp_stall
);
   import xsr_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_CALC = 3'b010,
      S_HOLD = 3'b100
   } state_type;

   state_type   state_ff, state_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] dvd_ff, dvd_in;
   logic [31:0] div_ff, div_in;
   logic [31:0] base_ff, base_in;
   logic [4:0]  cnt_ff, cnt_in;
   rsp_type     res_ff, res_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;
   logic [32:0] trial;
   logic [32:0] diff;
   logic [31:0] rem_step;
   logic        out_free;

   assign q_pop     = (state_ff == S_IDLE) && !q_stat.empty;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // One restoring step: shift in the next dividend bit, subtract if it fits.
   assign trial    = {rem_ff, dvd_ff[31]};
   assign diff     = trial - {1'b0, div_ff};
   assign rem_step = diff[32] ? trial[31:0] : diff[31:0];

   always_comb begin
      state_in     = state_ff;
      rem_in       = rem_ff;
      dvd_in       = dvd_ff;
      div_in       = div_ff;
      base_in      = base_ff;
      cnt_in       = cnt_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (!q_stat.empty) begin
               if (q_job.rem) begin
                  rem_in   = '0;
                  dvd_in   = q_job.word;
                  div_in   = q_job.divisor;
                  base_in  = q_job.base;
                  cnt_in   = '0;
                  state_in = S_CALC;
               end else begin
                  res_in.value        = q_job.base;
                  res_in.zero_modulus = q_job.flag;
                  state_in            = S_HOLD;
               end
            end
         end
         S_CALC: begin
            rem_in = rem_step;
            dvd_in = {dvd_ff[30:0], 1'b0};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == '1) begin
               res_in.value        = base_ff + rem_step;
               res_in.zero_modulus = 1'b0;
               state_in            = S_HOLD;
            end
         end
         S_HOLD: begin
            if (out_free) begin
               rsp_data_in  = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff      <= rem_in;
      dvd_ff      <= dvd_in;
      div_ff      <= div_in;
      base_ff     <= base_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

/* rtl/core/xorshift128_ranged_random_top.sv */
// Top level of the xorshift128 ranged random generator: register port, front, queue, back.
// Pass-through jobs (raw, zero modulus, empty range, unused) go from the queue to the result
//   register and on to rsp_valid; modulo and range draws first run 32 remainder steps.
// The back, with its single bit-serial remainder unit, finishes each job before it pops the next;
//   the front takes beats while the queue has room.
// Reset (synchronous, active high): default seeds and generator words, empty queue and output.
module xorshift128_ranged_random_top #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_valid,
   input  xsr_pkg::req_type                 req_data,
   output logic                             req_stall,
   // result channel
   output logic                             rsp_valid,
   output xsr_pkg::rsp_type                 rsp_data,
   input  logic                             rsp_stall,
   // register port
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [xsr_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [31:0]                      csr_pwdata,
   output logic [31:0]                      csr_prdata,
   output logic                             csr_pready
);
   import xsr_pkg::*;

   // Seed copies kept for read-back; the live generator words sit in the front.
   logic [31:0] seed_a_ff, seed_a_in;
   logic [31:0] seed_b_ff, seed_b_in;
   logic [31:0] seed_c_ff, seed_c_in;
   logic [31:0] seed_d_ff, seed_d_in;

   reg_idx_type seed_idx;
   seed_wr_type seed_wr;
   q_stat_type  q_stat;
   job_type     push_job;
   job_type     head_job;
   logic        q_push;
   logic        q_pop;

   // Register port: zero wait states, word index from the address.
   assign csr_pready   = 1'b1;
   assign seed_idx     = reg_idx_type'(csr_paddr[3:2]);
   assign seed_wr.en   = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign seed_wr.idx  = seed_idx;
   assign seed_wr.data = csr_pwdata;

   always_comb begin
      seed_a_in = seed_a_ff;
      seed_b_in = seed_b_ff;
      seed_c_in = seed_c_ff;
      seed_d_in = seed_d_ff;
      if (seed_wr.en) begin
         unique case (seed_idx)
            REG_SEED_A: seed_a_in = csr_pwdata;
            REG_SEED_B: seed_b_in = csr_pwdata;
            REG_SEED_C: seed_c_in = csr_pwdata;
            REG_SEED_D: seed_d_in = csr_pwdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (seed_idx)
         REG_SEED_A: csr_prdata = seed_a_ff;
         REG_SEED_B: csr_prdata = seed_b_ff;
         REG_SEED_C: csr_prdata = seed_c_ff;
         REG_SEED_D: csr_prdata = seed_d_ff;
         default:    csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_a_ff <= SEED_A_RESET;
         seed_b_ff <= SEED_B_RESET;
         seed_c_ff <= SEED_C_RESET;
         seed_d_ff <= SEED_D_RESET;
      end else begin
         seed_a_ff <= seed_a_in;
         seed_b_ff <= seed_b_in;
         seed_c_ff <= seed_c_in;
         seed_d_ff <= seed_d_in;
      end
   end

   // Front: takes the request beat, draws the next word when the command needs one,
   // and pushes a classified job in the same cycle.
   xsr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .seed_wr   (seed_wr),
      .q_stat    (q_stat),
      .q_push    (q_push),
      .q_job     (push_job)
   );

   // Queue lets the front run ahead while the remainder unit is busy.
   xsr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .pop      (q_pop),
      .head_job (head_job),
      .stat     (q_stat)
   );

   // Back: remainder, offset add, then the result register toward the consumer.
   xsr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_stat    (q_stat),
      .q_job     (head_job),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall)
   );

   // A zero-modulus error beat always carries a zero value.
   a_zero_mod_value : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.zero_modulus) |-> (rsp_data.value == '0))
      else $error("zero-modulus beat with non-zero value");

   // The front never pushes into a full queue.
   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_stat.full)
      else $error("job queue overflow");

   // The back never pops an empty queue.
   a_no_underflow : assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_stat.empty)
      else $error("job queue underflow");

   // A push into an empty queue leaves it non-empty on the next edge.
   a_push_lands : assert property (@(posedge clock) disable iff (reset)
      (q_push && q_stat.empty) |=> !q_stat.empty)
      else $error("pushed job lost");

endmodule
